// ===== hw/rtl/fct_pkg.sv =====
// fct_pkg: shared types and constants of the chain table engine
// item structs, request codes, register indexes, control/status structs
// no dependencies
package fct_pkg;

   // request codes
   localparam logic [1:0] REQ_READ  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_FIND  = 2'd2;
   localparam logic [1:0] REQ_FREE  = 2'd3;

   // configuration register indexes
   localparam logic [7:0] CSR_FREE_MARKER = 8'd0;
   localparam logic [7:0] CSR_NONE_FREE   = 8'd1;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] block_index;
      logic [7:0] entry_value;
   } req_item_type;

   typedef struct packed {
      logic [7:0] result_value;
      logic       found_free;
      logic [8:0] freed_count;
      logic       walk_overrun;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic read_issue;
      logic read_capture;
      logic write_req;
      logic find_step;
      logic chain_rd;
      logic chain_wr;
      logic resp_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic find_done;
      logic chain_stop;
      logic chain_loop;
      logic out_free;
   } dp_status_type;

endpackage

// ===== hw/rtl/fct_ram.sv =====
// fct_ram: generic single write port, single read port ram with registered read
// no dependencies
module fct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/fct_ctrl.sv =====
// fct_ctrl: sequencing state machine of the chain table engine
// depends on fct_pkg
module fct_ctrl
   import fct_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_type,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE         = 8'b0000_0001,
      ST_READ_ISSUE   = 8'b0000_0010,
      ST_READ_CAPTURE = 8'b0000_0100,
      ST_WRITE        = 8'b0000_1000,
      ST_FIND         = 8'b0001_0000,
      ST_CHAIN_RD     = 8'b0010_0000,
      ST_CHAIN_WR     = 8'b0100_0000,
      ST_RESP         = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_type)
                  REQ_READ:  state_in = ST_READ_ISSUE;
                  REQ_WRITE: state_in = ST_WRITE;
                  REQ_FIND:  state_in = ST_FIND;
                  REQ_FREE:  state_in = ST_CHAIN_RD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ_ISSUE: begin
            cmd.read_issue = 1'b1;
            state_in       = ST_READ_CAPTURE;
         end
         ST_READ_CAPTURE: begin
            cmd.read_capture = 1'b1;
            state_in         = ST_RESP;
         end
         ST_WRITE: begin
            cmd.write_req = 1'b1;
            state_in      = ST_RESP;
         end
         ST_FIND: begin
            cmd.find_step = 1'b1;
            if (status.find_done) begin
               state_in = ST_RESP;
            end
         end
         ST_CHAIN_RD: begin
            cmd.chain_rd = 1'b1;
            state_in     = status.chain_stop ? ST_RESP : ST_CHAIN_WR;
         end
         ST_CHAIN_WR: begin
            cmd.chain_wr = 1'b1;
            state_in     = status.chain_loop ? ST_RESP : ST_CHAIN_RD;
         end
         ST_RESP: begin
            if (status.out_free) begin
               cmd.resp_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/fct_datapath.sv =====
// fct_datapath: link table, valid bits, scan and chain counters, result register
// depends on fct_pkg and fct_ram
module fct_datapath
   import fct_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  req_item_type  req_item,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_item_type  rsp_item,
   input  logic          csr_valid,
   input  logic [7:0]    csr_index,
   input  logic [7:0]    csr_wdata
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(TABLE_ENTRIES);
   localparam logic [8:0] ENTRIES_9 = 9'(TABLE_ENTRIES);

   logic [7:0]               idx_ff, idx_in;
   logic [7:0]               val_ff, val_in;
   logic                     range_ff, range_in;
   logic [CNT_W-1:0]         scan_ff, scan_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic [7:0]               cur_ff, cur_in;
   logic [CNT_W-1:0]         step_ff, step_in;
   logic [7:0]               res_ff, res_in;
   logic                     found_ff, found_in;
   logic                     overrun_ff, overrun_in;
   logic [7:0]               marker_ff, marker_in;
   logic [7:0]               none_ff, none_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic                     vld_rd_ff, vld_rd_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_item_type             rsp_item_ff, rsp_item_in;

   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [7:0]       wr_data, rd_data, eff_data;
   logic             cur_in_range, chain_full, scan_more, hit;

   fct_ram #(
      .WIDTH(8),
      .DEPTH(TABLE_ENTRIES)
   ) u_link_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // entries never written since reset read as zero
   assign eff_data     = vld_rd_ff ? rd_data : 8'd0;
   assign cur_in_range = ({1'b0, cur_ff} < ENTRIES_9);
   assign chain_full   = (step_ff == LAST);
   assign scan_more    = (scan_ff != LAST);
   assign hit          = cmp_vld_ff && (eff_data == marker_ff);

   assign status.find_done  = hit || !scan_more;
   assign status.chain_stop = chain_full || !cur_in_range;
   assign status.chain_loop = (eff_data == cur_ff);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rd_en = (cmd.read_issue && range_ff) || (cmd.find_step && scan_more) ||
                  (cmd.chain_rd && !status.chain_stop);
   assign rd_addr = cmd.find_step ? scan_ff[IDX_W-1:0] :
                    cmd.chain_rd  ? cur_ff[IDX_W-1:0]  : idx_ff[IDX_W-1:0];
   assign wr_en   = (cmd.write_req && range_ff) || cmd.chain_wr;
   assign wr_addr = cmd.chain_wr ? cur_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_data = cmd.chain_wr ? marker_ff : val_ff;

   always_comb begin
      idx_in       = idx_ff;
      val_in       = val_ff;
      range_in     = range_ff;
      scan_in      = scan_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_idx_in   = cmp_idx_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      res_in       = res_ff;
      found_in     = found_ff;
      overrun_in   = overrun_ff;
      marker_in    = marker_ff;
      none_in      = none_ff;
      valid_in     = valid_ff;
      vld_rd_in    = vld_rd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;

      if (cmd.load) begin
         idx_in     = req_item.block_index;
         val_in     = req_item.entry_value;
         range_in   = ({1'b0, req_item.block_index} < ENTRIES_9);
         scan_in    = CNT_W'(1);
         cmp_vld_in = 1'b0;
         cur_in     = req_item.block_index;
         step_in    = '0;
         res_in     = 8'd0;
         found_in   = 1'b0;
         overrun_in = 1'b0;
      end

      if (cmd.read_capture && range_ff) begin
         res_in = eff_data;
      end

      // scan is one stage deep: read entry scan_ff, compare the one before
      if (cmd.find_step) begin
         cmp_vld_in = scan_more;
         cmp_idx_in = scan_ff[IDX_W-1:0];
         if (scan_more) begin
            scan_in = scan_ff + CNT_W'(1);
         end
         if (hit) begin
            res_in   = 8'(cmp_idx_ff);
            found_in = 1'b1;
         end else if (!scan_more) begin
            res_in = none_ff;
         end
      end

      if (cmd.chain_rd && chain_full) begin
         overrun_in = 1'b1;
      end

      if (cmd.chain_wr) begin
         step_in = step_ff + CNT_W'(1);
         if (!status.chain_loop) begin
            cur_in = eff_data;
         end
      end

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      if (rd_en) begin
         vld_rd_in = valid_ff[rd_addr];
      end

      if (cmd.resp_load) begin
         rsp_valid_in             = 1'b1;
         rsp_item_in.result_value = res_ff;
         rsp_item_in.found_free   = found_ff;
         rsp_item_in.freed_count  = 9'(step_ff);
         rsp_item_in.walk_overrun = overrun_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_FREE_MARKER: marker_in = csr_wdata;
            CSR_NONE_FREE:   none_in   = csr_wdata;
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff   <= 1'b0;
         marker_ff    <= 8'd0;
         none_ff      <= 8'd0;
         valid_ff     <= '0;
         vld_rd_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_vld_ff   <= cmp_vld_in;
         marker_ff    <= marker_in;
         none_ff      <= none_in;
         valid_ff     <= valid_in;
         vld_rd_ff    <= vld_rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      range_ff    <= range_in;
      scan_ff     <= scan_in;
      cmp_idx_ff  <= cmp_idx_in;
      cur_ff      <= cur_in;
      step_ff     <= step_in;
      res_ff      <= res_in;
      found_ff    <= found_in;
      overrun_ff  <= overrun_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== hw/rtl/fat_chain_table_engine.sv =====
// fat_chain_table_engine: top level of the file allocation table engine
// depends on fct_pkg, fct_ctrl, fct_datapath (which holds fct_ram)
//
// The engine keeps TABLE_ENTRIES 8-bit next-block links in a single-port-read
// ram and serves one request item at a time: read entry, write entry, find the
// first free entry from 1 upward, or free a chain by following links until a
// block points at itself or outside the table (bounded by TABLE_ENTRIES steps,
// overrun flagged). Every request gives exactly one result item. The table
// reads as zero after reset with no clearing pass: a per-entry valid bit masks
// never-written entries. From acceptance until the result is loaded into the
// output register, a read issues a ram read and then captures it, a write
// writes the entry, find free reads one entry per cycle and compares it in the
// cycle after, and free chain needs for each link a ram read, then the write
// of the free marker before the next link is known. The next item is accepted
// as soon as its result sits in the output register, even if that result has
// not been taken yet. Configuration writes are always taken and must only be
// issued while the engine is idle.
module fat_chain_table_engine
   import fct_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic         clock,
   input  logic         reset,
   // request item channel
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   // result item channel
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item,
   // configuration write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // register writes never stall
   assign csr_ready = 1'b1;

   // sequencer: one state per phase of each request kind
   fct_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_type (req_item.req_type),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   // table, counters and output register
   fct_datapath #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

endmodule
